// ===== hw/rtl/lfo_pkg.sv =====
package lfo_pkg;

    // Event selector codes.
    typedef enum logic [2:0] {
        K_METRICS  = 3'd0,
        K_CRC_ERR  = 3'd1,
        K_ACK_MISS = 3'd2,
        K_ACK_OK   = 3'd3,
        K_TICK     = 3'd4,
        K_FORCE    = 3'd5,
        K_RELEASE  = 3'd6
    } kind_t;

    // Link identifiers.
    localparam logic [1:0] LK_NONE = 2'd0;
    localparam logic [1:0] LK_WIFI = 2'd1;
    localparam logic [1:0] LK_FSO  = 2'd2;
    localparam logic [1:0] LK_LORA = 2'd3;

    // Reported state codes.
    localparam logic [2:0] SC_IDLE = 3'd0;
    localparam logic [2:0] SC_WIFI = 3'd1;
    localparam logic [2:0] SC_FSO  = 3'd2;
    localparam logic [2:0] SC_LORA = 3'd3;
    localparam logic [2:0] SC_WARN = 3'd4;

    // Configuration register indexes.
    localparam logic [2:0] CFG_FSO_DEGRADE  = 3'd0;
    localparam logic [2:0] CFG_FSO_RECOVER  = 3'd1;
    localparam logic [2:0] CFG_WIFI_DEGRADE = 3'd2;
    localparam logic [2:0] CFG_WIFI_RECOVER = 3'd3;
    localparam logic [2:0] CFG_CRC_DEGRADE  = 3'd4;
    localparam logic [2:0] CFG_CRC_RECOVER  = 3'd5;
    localparam logic [2:0] CFG_STABLE_HOLD  = 3'd6;
    localparam logic [2:0] CFG_WARN_HOLD    = 3'd7;

    typedef enum logic [4:0] {
        ST_IDLE = 5'b00001,
        ST_WIFI = 5'b00010,
        ST_FSO  = 5'b00100,
        ST_LORA = 5'b01000,
        ST_WARN = 5'b10000
    } state_t;

    // Link selector state that a transition touches.
    typedef struct packed {
        state_t      cur;
        state_t      prev;
        logic [15:0] stable;
    } fsm_t;

    // Link health derived from the averages, CRC rate and ACK misses.
    typedef struct packed {
        logic fso_healthy;
        logic fso_degraded;
        logic wifi_healthy;
        logic wifi_degraded;
    } health_t;

endpackage

// ===== hw/rtl/lfo_ram.sv =====
module lfo_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hw/rtl/link_failover_fsm.sv =====
// A request is taken into the input register, then its result into the result register; an output stall holds it.
// Throughput: one request per cycle while out_stall is low; the input register, the single-pass update and
// the result register form a two-stage pipeline, and the CRC window RAM is read ahead.
// Reset (rst_n, asynchronous, active low) returns to Wi-Fi active with cleared
// averages, timers, counters and override; the CRC window counts as all clear at once.
module link_failover_fsm
    import lfo_pkg::*;
#(
    parameter int WINDOW_LEN = 64,
    parameter int ALPHA_Q8   = 51,
    parameter int ACK_LIMIT  = 3
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [2:0]        kind,
    input  logic [11:0]       fso_sample_mv,
    input  logic signed [7:0] wifi_rssi,
    input  logic [15:0]       elapsed_ms,
    input  logic [1:0]        link_choice,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [2:0]        link_state,
    output logic [1:0]        active_link,
    output logic [1:0]        backup_link,
    output logic [6:0]        crc_rate_pct,
    output logic [7:0]        ack_fail_count,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_data
);

    localparam int POS_W = $clog2(WINDOW_LEN);
    localparam int REM_W = $clog2(WINDOW_LEN);
    localparam int Q100  = 100 / WINDOW_LEN;
    localparam int R100  = 100 % WINDOW_LEN;

    localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(WINDOW_LEN - 1);
    localparam logic [REM_W:0]    REM_LEN   = (REM_W + 1)'(WINDOW_LEN);
    localparam logic [REM_W:0]    REM_STEP  = (REM_W + 1)'(R100);
    localparam logic [6:0]        RATE_STEP = 7'(Q100);
    localparam logic signed [9:0] ALPHA_S   = 10'(ALPHA_Q8);
    localparam logic [7:0]        ACK_LIM   = 8'(ACK_LIMIT);

    // Configuration registers.
    logic [11:0]       fso_degrade_reg, fso_recover_reg;
    logic signed [7:0] wifi_degrade_reg, wifi_recover_reg;
    logic [6:0]        crc_degrade_reg, crc_recover_reg;
    logic [15:0]       stable_hold_reg, warn_hold_reg;

    // Input register.
    logic              iv_reg;
    kind_t             kind_reg;
    logic [11:0]       fso_sample_reg;
    logic signed [7:0] wifi_rssi_reg;
    logic [15:0]       elapsed_reg;
    logic [1:0]        link_choice_reg;

    // Block state.
    state_t            cur_state_reg, cur_state_next;
    state_t            prev_state_reg, prev_state_next;
    logic [15:0]       stable_timer_reg, stable_timer_next;
    logic [15:0]       warn_timer_reg, warn_timer_next;
    logic [19:0]       fso_avg_reg, fso_avg_next;
    logic signed [15:0] wifi_avg_reg, wifi_avg_next;
    logic [POS_W-1:0]  window_pos_reg, window_pos_next;
    logic              wrapped_reg, wrapped_next;
    logic [6:0]        crc_rate_reg, crc_rate_next;
    logic [REM_W-1:0]  crc_rem_reg, crc_rem_next;
    logic [7:0]        ack_misses_reg, ack_misses_next;
    logic              override_on_reg, override_on_next;
    logic [1:0]        override_link_reg, override_link_next;

    // Result register.
    logic              out_valid_reg;
    logic [2:0]        link_state_reg;
    logic [1:0]        active_link_reg, backup_link_reg;
    logic [6:0]        crc_rate_out_reg;
    logic [7:0]        ack_fail_reg;

    logic              advance;
    logic              push_en, push_bit, old_bit;
    logic [0:0]        win_rd_data;

    logic signed [20:0] fso_diff;
    logic signed [30:0] fso_prod, fso_sum;
    logic signed [16:0] wifi_diff;
    logic signed [26:0] wifi_prod, wifi_sum;

    health_t           hlt;
    logic [15:0]       st_dec, wt_dec;
    fsm_t              f0, f1, f2, f_ov;
    state_t            eval0, eval1, ov_target;
    logic [15:0]       tick_warn;
    logic              fso_ok_n, wifi_ok_n;
    logic [1:0]        act_n, bak_n;
    logic [REM_W:0]    rem_sum;

    function automatic state_t evaluate(state_t cur, state_t prev, health_t h);
        state_t r;
        r = ST_IDLE;
        case (cur)
            ST_IDLE, ST_LORA:
            begin
                if (h.wifi_healthy) r = ST_WIFI;
                else if (h.fso_healthy) r = ST_FSO;
                else r = ST_LORA;
            end
            ST_WIFI:
            begin
                if (h.wifi_degraded) r = h.fso_healthy ? ST_WARN : ST_LORA;
                else r = ST_WIFI;
            end
            ST_FSO:
            begin
                if (h.fso_degraded) r = h.wifi_healthy ? ST_WARN : ST_LORA;
                else r = ST_FSO;
            end
            ST_WARN:
            begin
                r = ST_WARN;
                if (prev == ST_WIFI)
                begin
                    if (h.fso_degraded && !h.wifi_healthy) r = ST_LORA;
                    else if (!h.fso_degraded) r = ST_FSO;
                    else if (!h.wifi_degraded) r = ST_WIFI;
                end
                else
                begin
                    if (h.wifi_degraded && !h.fso_healthy) r = ST_LORA;
                    else if (!h.wifi_degraded) r = ST_WIFI;
                    else if (!h.fso_degraded) r = ST_FSO;
                end
            end
            default: r = ST_IDLE;
        endcase
        return r;
    endfunction

    // A transition is blocked during the hold-off unless it enters warning.
    function automatic fsm_t move_to(fsm_t f, state_t target, logic [15:0] hold);
        fsm_t r;
        r = f;
        if (target != f.cur && !(f.stable != 16'd0 && target != ST_WARN))
        begin
            r.prev   = f.cur;
            r.cur    = target;
            r.stable = hold;
        end
        return r;
    endfunction

    function automatic logic [2:0] state_code(state_t s);
        logic [2:0] c;
        case (s)
            ST_WIFI: c = SC_WIFI;
            ST_FSO:  c = SC_FSO;
            ST_LORA: c = SC_LORA;
            ST_WARN: c = SC_WARN;
            default: c = SC_IDLE;
        endcase
        return c;
    endfunction

    // Handshakes.
    assign advance   = iv_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = iv_reg && !advance;
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fso_degrade_reg  <= 12'd1800;
            fso_recover_reg  <= 12'd2000;
            wifi_degrade_reg <= -8'sd75;
            wifi_recover_reg <= -8'sd65;
            crc_degrade_reg  <= 7'd20;
            crc_recover_reg  <= 7'd5;
            stable_hold_reg  <= 16'd3000;
            warn_hold_reg    <= 16'd500;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_FSO_DEGRADE:  fso_degrade_reg  <= cfg_data[11:0];
                CFG_FSO_RECOVER:  fso_recover_reg  <= cfg_data[11:0];
                CFG_WIFI_DEGRADE: wifi_degrade_reg <= $signed(cfg_data[7:0]);
                CFG_WIFI_RECOVER: wifi_recover_reg <= $signed(cfg_data[7:0]);
                CFG_CRC_DEGRADE:  crc_degrade_reg  <= cfg_data[6:0];
                CFG_CRC_RECOVER:  crc_recover_reg  <= cfg_data[6:0];
                CFG_STABLE_HOLD:  stable_hold_reg  <= cfg_data;
                CFG_WARN_HOLD:    warn_hold_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // Input register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            iv_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            iv_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            kind_reg        <= kind_t'(kind);
            fso_sample_reg  <= fso_sample_mv;
            wifi_rssi_reg   <= wifi_rssi;
            elapsed_reg     <= elapsed_ms;
            link_choice_reg <= link_choice;
        end
    end

    // CRC error window. Entries are written in order from zero, so the entry at the
    // write pointer holds valid data exactly when the pointer has wrapped at least once.
    assign push_en  = advance && (kind_reg == K_CRC_ERR || kind_reg == K_ACK_OK);
    assign push_bit = (kind_reg == K_CRC_ERR);
    assign old_bit  = wrapped_reg && win_rd_data[0];

    always_comb
    begin
        window_pos_next = window_pos_reg;
        wrapped_next    = wrapped_reg;
        if (push_en)
        begin
            if (window_pos_reg == POS_LAST)
            begin
                window_pos_next = '0;
                wrapped_next    = 1'b1;
            end
            else
            begin
                window_pos_next = window_pos_reg + 1'b1;
            end
        end
    end

    lfo_ram #(
        .WIDTH (1),
        .DEPTH (WINDOW_LEN)
    ) u_window (
        .clk     (clk),
        .wr_en   (push_en),
        .wr_addr (window_pos_reg),
        .wr_data (push_bit),
        .rd_addr (window_pos_next),
        .rd_data (win_rd_data)
    );

    // The CRC percent is kept as quotient and remainder of 100 * errors over
    // the window length, so each error added or dropped is one small step.
    always_comb
    begin
        crc_rate_next = crc_rate_reg;
        crc_rem_next  = crc_rem_reg;
        rem_sum       = {1'b0, crc_rem_reg} + REM_STEP;
        if (push_en && push_bit && !old_bit)
        begin
            if (rem_sum >= REM_LEN)
            begin
                crc_rem_next  = REM_W'(rem_sum - REM_LEN);
                crc_rate_next = crc_rate_reg + RATE_STEP + 7'd1;
            end
            else
            begin
                crc_rem_next  = rem_sum[REM_W-1:0];
                crc_rate_next = crc_rate_reg + RATE_STEP;
            end
        end
        else if (push_en && !push_bit && old_bit)
        begin
            if ({1'b0, crc_rem_reg} >= REM_STEP)
            begin
                crc_rem_next  = REM_W'({1'b0, crc_rem_reg} - REM_STEP);
                crc_rate_next = crc_rate_reg - RATE_STEP;
            end
            else
            begin
                crc_rem_next  = REM_W'({1'b0, crc_rem_reg} + REM_LEN - REM_STEP);
                crc_rate_next = crc_rate_reg - RATE_STEP - 7'd1;
            end
        end
    end

    // Averages as avg + alpha * (sample - avg), rounded half up.
    assign fso_diff  = $signed({1'b0, fso_sample_reg, 8'h00}) - $signed({1'b0, fso_avg_reg});
    assign fso_prod  = 31'(fso_diff) * 31'(ALPHA_S);
    assign fso_sum   = $signed({3'b000, fso_avg_reg, 8'h00}) + fso_prod + 31'sd128;
    assign wifi_diff = 17'($signed({wifi_rssi_reg, 8'h00})) - 17'(wifi_avg_reg);
    assign wifi_prod = 27'(wifi_diff) * 27'(ALPHA_S);
    assign wifi_sum  = 27'($signed({wifi_avg_reg, 8'h00})) + wifi_prod + 27'sd128;

    // Health from the state before the request; a tick does not change it.
    always_comb
    begin
        hlt.fso_healthy   = (fso_avg_reg >= {fso_recover_reg, 8'h00}) &&
                            (crc_rate_reg < crc_recover_reg);
        hlt.fso_degraded  = (fso_avg_reg < {fso_degrade_reg, 8'h00}) ||
                            (crc_rate_reg >= crc_degrade_reg);
        hlt.wifi_healthy  = (wifi_avg_reg >= $signed({wifi_recover_reg, 8'h00})) &&
                            (crc_rate_reg < crc_recover_reg);
        hlt.wifi_degraded = (wifi_avg_reg < $signed({wifi_degrade_reg, 8'h00})) ||
                            (crc_rate_reg >= crc_degrade_reg) ||
                            (ack_misses_reg >= ACK_LIM);
    end

    // Tick: count down, settle an expired warning, then evaluate once more; under an override, move to the forced link.
    always_comb
    begin
        st_dec = (stable_timer_reg > elapsed_reg) ? stable_timer_reg - elapsed_reg : 16'd0;
        wt_dec = (warn_timer_reg > elapsed_reg) ? warn_timer_reg - elapsed_reg : 16'd0;
        f0.cur    = cur_state_reg;
        f0.prev   = prev_state_reg;
        f0.stable = st_dec;
        eval0 = evaluate(cur_state_reg, prev_state_reg, hlt);
        if (warn_timer_reg != 16'd0 && wt_dec == 16'd0 && cur_state_reg == ST_WARN)
        begin
            f1 = move_to(f0, eval0, stable_hold_reg);
        end
        else
        begin
            f1 = f0;
        end
        eval1 = evaluate(f1.cur, f1.prev, hlt);
        tick_warn = wt_dec;
        if (eval1 != f1.cur && f1.cur != ST_WARN && eval1 == ST_WARN)
        begin
            f2.cur    = ST_WARN;
            f2.prev   = f1.cur;
            f2.stable = f1.stable;
            tick_warn = warn_hold_reg;
        end
        else
        begin
            f2 = move_to(f1, eval1, stable_hold_reg);
        end

        case (override_link_reg)
            LK_WIFI: ov_target = ST_WIFI;
            LK_FSO:  ov_target = ST_FSO;
            LK_LORA: ov_target = ST_LORA;
            default: ov_target = ST_IDLE;
        endcase
        f_ov.cur    = cur_state_reg;
        f_ov.prev   = prev_state_reg;
        f_ov.stable = stable_timer_reg;
        f_ov = move_to(f_ov, ov_target, stable_hold_reg);
    end

    always_comb
    begin
        cur_state_next     = cur_state_reg;
        prev_state_next    = prev_state_reg;
        stable_timer_next  = stable_timer_reg;
        warn_timer_next    = warn_timer_reg;
        fso_avg_next       = fso_avg_reg;
        wifi_avg_next      = wifi_avg_reg;
        ack_misses_next    = ack_misses_reg;
        override_on_next   = override_on_reg;
        override_link_next = override_link_reg;
        case (kind_reg)
            K_METRICS:
            begin
                fso_avg_next  = fso_sum[27:8];
                wifi_avg_next = wifi_sum[23:8];
            end
            K_ACK_MISS:
            begin
                if (ack_misses_reg != 8'hFF) ack_misses_next = ack_misses_reg + 8'd1;
            end
            K_ACK_OK:
            begin
                ack_misses_next = 8'd0;
            end
            K_TICK:
            begin
                if (override_on_reg)
                begin
                    cur_state_next    = f_ov.cur;
                    prev_state_next   = f_ov.prev;
                    stable_timer_next = f_ov.stable;
                end
                else
                begin
                    cur_state_next    = f2.cur;
                    prev_state_next   = f2.prev;
                    stable_timer_next = f2.stable;
                    warn_timer_next   = tick_warn;
                end
            end
            K_FORCE:
            begin
                override_on_next   = 1'b1;
                override_link_next = link_choice_reg;
            end
            K_RELEASE:
            begin
                override_on_next   = 1'b0;
                override_link_next = LK_NONE;
            end
            default: ;
        endcase
    end

    // Link view after the request.
    always_comb
    begin
        fso_ok_n  = (fso_avg_next >= {fso_recover_reg, 8'h00});
        wifi_ok_n = (wifi_avg_next >= $signed({wifi_recover_reg, 8'h00}));
        act_n = LK_NONE;
        bak_n = LK_NONE;
        case (cur_state_next)
            ST_WIFI:
            begin
                act_n = LK_WIFI;
                bak_n = LK_FSO;
            end
            ST_FSO:
            begin
                act_n = LK_FSO;
                bak_n = LK_WIFI;
            end
            ST_LORA:
            begin
                act_n = LK_LORA;
                bak_n = wifi_ok_n ? LK_WIFI : (fso_ok_n ? LK_FSO : LK_NONE);
            end
            ST_WARN:
            begin
                act_n = (prev_state_next == ST_WIFI) ? LK_WIFI : LK_FSO;
                bak_n = (prev_state_next == ST_WIFI) ? LK_FSO : LK_WIFI;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_state_reg     <= ST_WIFI;
            prev_state_reg    <= ST_IDLE;
            stable_timer_reg  <= 16'd0;
            warn_timer_reg    <= 16'd0;
            fso_avg_reg       <= 20'd0;
            wifi_avg_reg      <= 16'sd0;
            window_pos_reg    <= '0;
            wrapped_reg       <= 1'b0;
            crc_rate_reg      <= 7'd0;
            crc_rem_reg       <= '0;
            ack_misses_reg    <= 8'd0;
            override_on_reg   <= 1'b0;
            override_link_reg <= LK_NONE;
        end
        else if (advance)
        begin
            cur_state_reg     <= cur_state_next;
            prev_state_reg    <= prev_state_next;
            stable_timer_reg  <= stable_timer_next;
            warn_timer_reg    <= warn_timer_next;
            fso_avg_reg       <= fso_avg_next;
            wifi_avg_reg      <= wifi_avg_next;
            window_pos_reg    <= window_pos_next;
            wrapped_reg       <= wrapped_next;
            crc_rate_reg      <= crc_rate_next;
            crc_rem_reg       <= crc_rem_next;
            ack_misses_reg    <= ack_misses_next;
            override_on_reg   <= override_on_next;
            override_link_reg <= override_link_next;
        end
    end

    // Result register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (!out_valid_reg || !out_stall)
        begin
            out_valid_reg <= advance;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            link_state_reg   <= state_code(cur_state_next);
            active_link_reg  <= act_n;
            backup_link_reg  <= bak_n;
            crc_rate_out_reg <= crc_rate_next;
            ack_fail_reg     <= ack_misses_next;
        end
    end

    assign out_valid      = out_valid_reg;
    assign link_state     = link_state_reg;
    assign active_link    = active_link_reg;
    assign backup_link    = backup_link_reg;
    assign crc_rate_pct   = crc_rate_out_reg;
    assign ack_fail_count = ack_fail_reg;

`ifndef SYNTH
    a_rate_bound: assert property (@(posedge clk) disable iff (!rst_n)
        crc_rate_reg <= 7'd100)
        else $error("CRC percent exceeds 100");

    a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, crc_rem_reg} < REM_LEN)
        else $error("CRC remainder not below window length");

    a_state_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        $onehot(cur_state_reg) && $onehot(prev_state_reg))
        else $error("state register lost its one-hot code");

    a_no_stall_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> !in_stall)
        else $error("input stalled while result register is empty");
`endif

endmodule
